// ----- hw/rtl/pps_pkg.sv -----
package pps_pkg;

	localparam int POSITION_BITS = 16;
	localparam int GAIN_W        = 20;
	localparam int TARGET_W      = 16;
	localparam int ILIM_W        = 16;
	localparam int DLIM_W        = 8;
	localparam int FRAC_W        = 16;

	localparam int ERR_W   = ((POSITION_BITS > TARGET_W) ? POSITION_BITS : TARGET_W) + 1;
	localparam int ESUM_W  = ILIM_W + 1;
	localparam int SUM_W   = ((ESUM_W > ERR_W) ? ESUM_W : ERR_W) + 1;
	localparam int DER_W   = ERR_W + 1;
	localparam int PROD_W  = GAIN_W + 1 + DER_W;
	localparam int V_W     = PROD_W + 2;
	localparam int VLIM_W  = DLIM_W + FRAC_W + 1;

	localparam int CFG_DATA_W = 20;
	localparam int CFG_IDX_W  = 3;

	localparam int QUEUE_DEPTH = 2;

	localparam logic [CFG_IDX_W-1:0] REG_GAIN_P         = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_I         = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_D         = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_POS     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_STOP_MARK      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LIMIT = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIMIT    = 3'd6;

	localparam logic [GAIN_W-1:0]   RST_GAIN_P         = 20'd13107;
	localparam logic [GAIN_W-1:0]   RST_GAIN_I         = 20'd328;
	localparam logic [GAIN_W-1:0]   RST_GAIN_D         = 20'd3277;
	localparam logic [TARGET_W-1:0] RST_TARGET_POS     = 16'd210;
	localparam logic [TARGET_W-1:0] RST_STOP_MARK      = 16'd200;
	localparam logic [ILIM_W-1:0]   RST_INTEGRAL_LIMIT = 16'd1000;
	localparam logic [DLIM_W-1:0]   RST_DRIVE_LIMIT    = 8'd20;

	localparam logic [1:0] ACT_DRIVE = 2'd0;
	localparam logic [1:0] ACT_HOLD  = 2'd1;
	localparam logic [1:0] ACT_STOP  = 2'd2;
	localparam logic [1:0] ACT_IDLE  = 2'd3;

	typedef struct packed {
		logic                            cmd;
		logic signed [POSITION_BITS-1:0] measured_position;
	} in_item_t;

	typedef struct packed {
		logic [1:0]        action;
		logic [DLIM_W-1:0] drive_magnitude;
		logic              drive_reverse;
	} out_item_t;

	typedef struct packed {
		logic [GAIN_W-1:0]          gain_p;
		logic [GAIN_W-1:0]          gain_i;
		logic [GAIN_W-1:0]          gain_d;
		logic signed [TARGET_W-1:0] target_position;
		logic signed [TARGET_W-1:0] stop_mark;
		logic [ILIM_W-1:0]          integral_limit;
		logic [DLIM_W-1:0]          drive_limit;
	} cfg_t;

	// one classified tick on its way from front to back
	typedef struct packed {
		logic [1:0]               action;
		logic signed [ERR_W-1:0]  err;
		logic signed [ESUM_W-1:0] esum;
		logic signed [DER_W-1:0]  deriv;
	} work_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

// ----- hw/rtl/pid_position_stop_controller.sv -----
// channel   | direction | handshake                  | payload
// ----------+-----------+----------------------------+-------------------------------
// item      | in        | item_valid / item_stall    | cmd, measured_position
// result    | out       | result_valid / result_stall| action, drive_magnitude, reverse
// cfg       | in        | cfg_we                     | cfg_index, cfg_data
//
// one item per cycle while item_stall is low; a result passes the queue slot,
// then the multiplier stage, then the clamp and output register
// the error, integral and finished state update in the front
// reset loads the register defaults and clears integral, last error and finished
// result_stall backs up the back pipeline, then the queue; item_stall rises when
// the queue is full
module pid_position_stop_controller #(
	parameter int QUEUE_DEPTH = pps_pkg::QUEUE_DEPTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [pps_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pps_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              item_valid,
	output logic                              item_stall,
	input  pps_pkg::in_item_t                 item,
	output logic                              result_valid,
	input  logic                              result_stall,
	output pps_pkg::out_item_t                result
);
	import pps_pkg::*;

	cfg_t      cfg_q;
	q_status_t q_status;
	work_t     push_work;
	work_t     pop_work;
	logic      push;
	logic      pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_p          <= RST_GAIN_P;
			cfg_q.gain_i          <= RST_GAIN_I;
			cfg_q.gain_d          <= RST_GAIN_D;
			cfg_q.target_position <= RST_TARGET_POS;
			cfg_q.stop_mark       <= RST_STOP_MARK;
			cfg_q.integral_limit  <= RST_INTEGRAL_LIMIT;
			cfg_q.drive_limit     <= RST_DRIVE_LIMIT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GAIN_P:         cfg_q.gain_p          <= cfg_data[GAIN_W-1:0];
				REG_GAIN_I:         cfg_q.gain_i          <= cfg_data[GAIN_W-1:0];
				REG_GAIN_D:         cfg_q.gain_d          <= cfg_data[GAIN_W-1:0];
				REG_TARGET_POS:     cfg_q.target_position <= cfg_data[TARGET_W-1:0];
				REG_STOP_MARK:      cfg_q.stop_mark       <= cfg_data[TARGET_W-1:0];
				REG_INTEGRAL_LIMIT: cfg_q.integral_limit  <= cfg_data[ILIM_W-1:0];
				REG_DRIVE_LIMIT:    cfg_q.drive_limit     <= cfg_data[DLIM_W-1:0];
				default: begin
				end
			endcase
		end
	end

	pps_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.q_status   (q_status),
		.push       (push),
		.work       (push_work)
	);

	pps_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_work),
		.pop       (pop),
		.pop_data  (pop_work),
		.status    (q_status)
	);

	pps_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_status     (q_status),
		.work         (pop_work),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

// ----- hw/rtl/pps_queue.sv -----
module pps_queue #(
	parameter int DEPTH = pps_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  pps_pkg::work_t    push_data,
	input  logic              pop,
	output pps_pkg::work_t    pop_data,
	output pps_pkg::q_status_t status
);
	import pps_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	work_t             slot_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push;
	logic              do_pop;

	assign status.full  = (count_q == CNT_W'(DEPTH));
	assign status.empty = (count_q == '0);
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign pop_data     = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- hw/rtl/pps_front.sv -----
module pps_front (
	input  logic               clk,
	input  logic               arst_n,
	input  pps_pkg::cfg_t      cfg,
	input  logic               item_valid,
	output logic               item_stall,
	input  pps_pkg::in_item_t  item,
	input  pps_pkg::q_status_t q_status,
	output logic               push,
	output pps_pkg::work_t     work
);
	import pps_pkg::*;

	logic signed [ESUM_W-1:0]        esum_q;
	logic signed [ERR_W-1:0]         last_err_q;
	logic                            finished_q;

	logic signed [POSITION_BITS-1:0] pos;
	logic signed [TARGET_W-1:0]      tgt;
	logic signed [TARGET_W-1:0]      stop;
	logic signed [ERR_W-1:0]         err;
	logic signed [SUM_W-1:0]         sum;
	logic signed [SUM_W-1:0]         lim;
	logic signed [SUM_W-1:0]         sum_cl;
	logic signed [ESUM_W-1:0]        esum_nx;
	logic signed [DER_W-1:0]         deriv;
	logic [1:0]                      action;

	assign pos  = item.measured_position;
	assign tgt  = cfg.target_position;
	assign stop = cfg.stop_mark;

	assign item_stall = q_status.full;
	assign push       = item_valid && !q_status.full;

	always_comb begin
		err = ERR_W'(tgt) - ERR_W'(pos);
		sum = SUM_W'(esum_q) + SUM_W'(err);
		lim = SUM_W'(signed'({1'b0, cfg.integral_limit}));
		priority if (sum > lim) begin
			sum_cl = lim;
		end else if (sum < -lim) begin
			sum_cl = -lim;
		end else begin
			sum_cl = sum;
		end
		esum_nx = ESUM_W'(sum_cl);
		deriv   = DER_W'(err) - DER_W'(last_err_q);

		priority if (item.cmd || finished_q) begin
			action = ACT_IDLE;
		end else if (ERR_W'(pos) >= ERR_W'(tgt)) begin
			action = ACT_HOLD;
		end else if (ERR_W'(pos) > ERR_W'(stop)) begin
			action = ACT_STOP;
		end else begin
			action = ACT_DRIVE;
		end

		work.action = action;
		work.err    = err;
		work.esum   = esum_nx;
		work.deriv  = deriv;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esum_q     <= '0;
			last_err_q <= '0;
			finished_q <= 1'b0;
		end else if (push) begin
			if (item.cmd) begin
				esum_q     <= '0;
				last_err_q <= '0;
				finished_q <= 1'b0;
			end else if (!finished_q) begin
				esum_q     <= esum_nx;
				last_err_q <= err;
				if (action == ACT_STOP) begin
					finished_q <= 1'b1;
				end
			end
		end
	end

endmodule

// ----- hw/rtl/pps_back.sv -----
module pps_back (
	input  logic               clk,
	input  logic               arst_n,
	input  pps_pkg::cfg_t      cfg,
	input  pps_pkg::q_status_t q_status,
	input  pps_pkg::work_t     work,
	output logic               pop,
	output logic               result_valid,
	input  logic               result_stall,
	output pps_pkg::out_item_t result
);
	import pps_pkg::*;

	logic                     valid_s1;
	logic [1:0]               action_s1;
	logic signed [PROD_W-1:0] prod_p_s1;
	logic signed [PROD_W-1:0] prod_i_s1;
	logic signed [PROD_W-1:0] prod_d_s1;

	logic                     valid_s2;
	out_item_t                result_s2;

	logic                     ready_s2;
	logic                     load_s1;
	logic signed [GAIN_W:0]   gp;
	logic signed [GAIN_W:0]   gi;
	logic signed [GAIN_W:0]   gd;
	logic signed [PROD_W-1:0] prod_p;
	logic signed [PROD_W-1:0] prod_i;
	logic signed [PROD_W-1:0] prod_d;
	logic signed [V_W-1:0]    v;
	logic signed [V_W-1:0]    vlim;
	logic signed [V_W-1:0]    v_cl;
	logic signed [V_W-1:0]    v_neg;
	out_item_t                res_nx;

	assign ready_s2 = !valid_s2 || !result_stall;
	assign load_s1  = !valid_s1 || ready_s2;
	assign pop      = load_s1 && !q_status.empty;

	assign gp = signed'({1'b0, cfg.gain_p});
	assign gi = signed'({1'b0, cfg.gain_i});
	assign gd = signed'({1'b0, cfg.gain_d});

	assign prod_p = gp * PROD_W'(work.err);
	assign prod_i = gi * PROD_W'(work.esum);
	assign prod_d = gd * PROD_W'(work.deriv);

	always_comb begin
		v    = V_W'(prod_p_s1) + V_W'(prod_i_s1) + V_W'(prod_d_s1);
		vlim = V_W'(signed'({1'b0, cfg.drive_limit, {FRAC_W{1'b0}}}));
		priority if (v > vlim) begin
			v_cl = vlim;
		end else if (v < -vlim) begin
			v_cl = -vlim;
		end else begin
			v_cl = v;
		end
		v_neg = -v_cl;

		res_nx.action          = action_s1;
		res_nx.drive_magnitude = '0;
		res_nx.drive_reverse   = 1'b0;
		if (action_s1 == ACT_DRIVE) begin
			// magnitude truncates toward zero, zero counts as reverse
			if (v_cl > 0) begin
				res_nx.drive_magnitude = v_cl[FRAC_W +: DLIM_W];
			end else begin
				res_nx.drive_magnitude = v_neg[FRAC_W +: DLIM_W];
				res_nx.drive_reverse   = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			action_s1 <= work.action;
			prod_p_s1 <= prod_p;
			prod_i_s1 <= prod_i;
			prod_d_s1 <= prod_d;
		end
		if (ready_s2 && valid_s1) begin
			result_s2 <= res_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (load_s1) begin
				valid_s1 <= pop;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

endmodule
